// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the serial frame deframer.
// Holds status codes, the minimum frame length and the config/result structs.
// No dependencies.
package sfd_pkg;

    // Status codes carried with every result transfer
    localparam logic [2:0] ST_SYNC       = 3'd0;
    localparam logic [2:0] ST_LENGTH     = 3'd1;
    localparam logic [2:0] ST_TYPE       = 3'd2;
    localparam logic [2:0] ST_PAYLOAD    = 3'd3;
    localparam logic [2:0] ST_READY      = 3'd4;
    localparam logic [2:0] ST_ERR_LENGTH = 3'd5;
    localparam logic [2:0] ST_ERR_CRC    = 3'd6;
    localparam logic [2:0] ST_ERR_SYNC   = 3'd7;

    // Configuration register indexes
    localparam logic CFG_CRC_POLY    = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] CRC_POLY_RST    = 8'd213;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd60;

    // Smallest legal length byte (type byte plus CRC byte)
    localparam logic [7:0] FRAME_LEN_MIN = 8'd2;

    typedef struct packed {
        logic [7:0] crc_poly;
        logic [7:0] max_payload;
    } sfd_cfg_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } sfd_result_t;

endpackage

// ===== rtl/sfd_crc8.sv =====
// One-byte CRC-8 update, MSB first, implicit x^8 term.
// Depends on sfd_pkg only through the common import style.
module sfd_crc8
    import sfd_pkg::*;
(
    input  logic [7:0] crc,
    input  logic [7:0] data,
    input  logic [7:0] poly,
    output logic [7:0] crc_out
);

    always_comb
    begin
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/sfd_parser.sv =====
// Frame walker: holds the frame state and computes one result per byte.
// Depends on sfd_pkg and sfd_crc8.
module sfd_parser
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  byte_val,
    input  sfd_cfg_t    cfg,
    output sfd_result_t result
);

    logic       sync_seen_reg,  sync_seen_next;
    logic [7:0] frame_len_reg,  frame_len_next;
    logic [7:0] frame_type_reg, frame_type_next;
    logic [7:0] pay_cnt_reg,    pay_cnt_next;
    logic [7:0] crc_reg,        crc_next;
    logic [7:0] crc_upd;
    logic [8:0] len_limit;
    logic [8:0] last_cnt;
    logic [2:0] status;
    logic [7:0] index;

    sfd_crc8 u_crc8
    (
        .crc     (crc_reg),
        .data    (byte_val),
        .poly    (cfg.crc_poly),
        .crc_out (crc_upd)
    );

    assign len_limit = {1'b0, cfg.max_payload} + {1'b0, FRAME_LEN_MIN};
    assign last_cnt  = {1'b0, frame_len_reg} - 9'd1;

    always_comb
    begin
        sync_seen_next  = sync_seen_reg;
        frame_len_next  = frame_len_reg;
        frame_type_next = frame_type_reg;
        pay_cnt_next    = pay_cnt_reg;
        crc_next        = crc_reg;
        status          = ST_SYNC;
        index           = 8'd0;

        if (!sync_seen_reg)
        begin
            // hunt: any non-zero byte opens a frame
            sync_seen_next  = (byte_val != 8'd0);
            frame_len_next  = 8'd0;
            frame_type_next = 8'd0;
            pay_cnt_next    = 8'd0;
            crc_next        = 8'd0;
            status          = ST_SYNC;
        end
        else if (frame_len_reg == 8'd0)
        begin
            if (byte_val >= FRAME_LEN_MIN && {1'b0, byte_val} <= len_limit)
            begin
                frame_len_next = byte_val;
                status         = ST_LENGTH;
            end
            else
            begin
                sync_seen_next = 1'b0;
                status         = ST_ERR_LENGTH;
            end
        end
        else if (frame_type_reg == 8'd0)
        begin
            frame_type_next = byte_val;
            crc_next        = crc_upd;
            status          = ST_TYPE;
        end
        else if ({1'b0, pay_cnt_reg} < last_cnt)
        begin
            index        = pay_cnt_reg;
            pay_cnt_next = pay_cnt_reg + 8'd1;
            if ({1'b0, pay_cnt_next} == last_cnt)
            begin
                status = (byte_val == crc_reg) ? ST_READY : ST_ERR_CRC;
            end
            else
            begin
                crc_next = crc_upd;
                status   = ST_PAYLOAD;
            end
        end
        else
        begin
            sync_seen_next = 1'b0;
            status         = ST_ERR_SYNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_seen_reg  <= 1'b0;
            frame_len_reg  <= 8'd0;
            frame_type_reg <= 8'd0;
            pay_cnt_reg    <= 8'd0;
            crc_reg        <= 8'd0;
        end
        else if (advance)
        begin
            sync_seen_reg  <= sync_seen_next;
            frame_len_reg  <= frame_len_next;
            frame_type_reg <= frame_type_next;
            pay_cnt_reg    <= pay_cnt_next;
            crc_reg        <= crc_next;
        end
    end

    assign result.status        = status;
    assign result.data_byte     = byte_val;
    assign result.payload_index = index;
    assign result.frame_type    = frame_type_next;
    assign result.frame_length  = frame_len_next;

endmodule

// ===== rtl/serial_frame_deframer_crc8.sv =====
// Top level of the byte-serial frame deframer with running CRC-8.
// Depends on sfd_pkg, sfd_parser and sfd_crc8.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------------
//   input   | in        | in_valid / in_stall    | byte_in
//   output  | out       | out_valid / out_stall  | status, data_byte, payload_index,
//           |           |                        | frame_type_out, frame_length_out
//   config  | in        | cfg_we                 | cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; each byte passes the input
// register and then the result register. The frame state steps once per byte
// (length check, CRC-8 update, count). Reset clears the frame state, the pipeline
// valids and loads the register defaults (polynomial 213, max payload 60). A
// stalled result is held in the result register while one further byte may still
// be taken into the input register; after that in_stall rises until the result
// is taken.
module serial_frame_deframer_crc8
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] data_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_type_out,
    output logic [7:0] frame_length_out,
    // configuration port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    sfd_cfg_t    cfg_reg;
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    sfd_result_t res_reg;
    sfd_result_t res_next;
    logic        res_free;
    logic        advance;

    // Configuration registers: the user must write them only while the block is idle; not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_poly    <= CRC_POLY_RST;
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CRC_POLY:    cfg_reg.crc_poly    <= cfg_data;
                CFG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Result register is free when empty or when its transfer completes now
    assign res_free = !out_vld_reg || !out_stall;
    // Advance the held byte into the parser when the result slot can take it
    assign advance  = in_vld_reg && res_free;
    // Input register takes a new byte when empty or draining this cycle
    assign in_stall = in_vld_reg && !res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= byte_in;
        end
    end

    sfd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .byte_val (in_byte_reg),
        .cfg      (cfg_reg),
        .result   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Hold the result while stalled; load a fresh one on each advance
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign status           = res_reg.status;
    assign data_byte        = res_reg.data_byte;
    assign payload_index    = res_reg.payload_index;
    assign frame_type_out   = res_reg.frame_type;
    assign frame_length_out = res_reg.frame_length;

    // A payload byte never reaches the slot of the CRC byte
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PAYLOAD
            |-> ({1'b0, payload_index} + 9'd2) < {1'b0, frame_length_out})
        else $error("payload index runs past the CRC slot");

    // A sync result always shows a cleared frame
    a_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SYNC
            |-> frame_type_out == 8'd0 && frame_length_out == 8'd0)
        else $error("sync result with stale frame fields");

    // Statuses other than payload, ready and CRC error carry a zero index
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SYNC || status == ST_LENGTH || status == ST_TYPE
            || status == ST_ERR_LENGTH || status == ST_ERR_SYNC)
            |-> payload_index == 8'd0)
        else $error("non-zero index outside the payload area");

endmodule
